// ===== rtl/sobel_magnitude_angle_stream_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SOBEL_MAGNITUDE_ANGLE_STREAM_CORE_DEFINES_SVH
`define SOBEL_MAGNITUDE_ANGLE_STREAM_CORE_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define SMAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define SMAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/smas_pkg.sv =====
`timescale 1ns / 1ps
package smas_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int SIZE_W       = 11;
  localparam int PIX_W        = 8;
  localparam int GRAD_W       = 11;
  localparam int CORDIC_STEPS = 58;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PRESCALE     = 42;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [7:0]        THR_RESET    = 8'd75;

  // angle code bounds: phi >= sign(m)*floor(|m|*ANG_NUM*2^60/ANG_DEN), m = 100k - ANG_OFS
  localparam logic [30:0] ANG_DEN = 31'd1275000000;
  localparam logic signed [19:0] ANG_NUM = 20'sd314159;
  localparam logic signed [16:0] ANG_OFS = 17'sd12751;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ANGLE_THR    = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  typedef enum logic {
    FR_IDLE,
    FR_CALC
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CORDIC,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_SEARCH,
    BK_EMIT
  } back_state_t;

  // One interior result and the output positions it covers.
  typedef struct packed {
    logic signed [GRAD_W-1:0] sx;
    logic signed [GRAD_W-1:0] sy;
    logic [7:0]               mag;
    logic                     need_angle;
    logic [ROW_W-1:0]         row_a;
    logic [ROW_W-1:0]         row_b;
    logic                     two_rows;
    logic [COL_W-1:0]         col_a;
    logic [COL_W-1:0]         col_b;
    logic                     two_cols;
    logic                     frame_end;
  } job_t;

  typedef logic signed [63:0] atan_tab_t [CORDIC_STEPS];

  // unsigned quotient by shift and subtract, used for building constants only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 by the alternating series, i >= 1
  function automatic logic signed [63:0] atan_pow2(input int i);
    logic [63:0]        p;
    logic signed [63:0] sum;
    logic [63:0]        n;
    logic [63:0]        t;
    p   = 64'd1 << (60 - i);
    sum = '0;
    n   = '0;
    while (p != 0) begin
      t = udiv64(p, (n << 1) + 64'd1);
      if (n[0] == 1'b0) sum = sum + $signed(t);
      else sum = sum - $signed(t);
      p = p >> (2 * i);
      n = n + 1;
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] atan_recip5();
    logic [63:0]        p;
    logic signed [63:0] sum;
    logic [63:0]        n;
    logic [63:0]        t;
    p   = udiv64(64'd1 << 60, 64'd5);
    sum = '0;
    n   = '0;
    while (p != 0) begin
      t = udiv64(p, (n << 1) + 64'd1);
      if (n[0] == 1'b0) sum = sum + $signed(t);
      else sum = sum - $signed(t);
      p = udiv64(p, 64'd25);
      n = n + 1;
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] atan_recip239();
    logic [63:0]        p;
    logic signed [63:0] sum;
    logic [63:0]        n;
    logic [63:0]        t;
    p   = udiv64(64'd1 << 60, 64'd239);
    sum = '0;
    n   = '0;
    while (p != 0) begin
      t = udiv64(p, (n << 1) + 64'd1);
      if (n[0] == 1'b0) sum = sum + $signed(t);
      else sum = sum - $signed(t);
      p = udiv64(p, 64'd57121);
      n = n + 1;
    end
    return sum;
  endfunction

  // pi/4 by Machin's formula
  function automatic logic signed [63:0] atan_one();
    return 64'sd4 * atan_recip5() - atan_recip239();
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    tab[0] = atan_one();
    for (int i = 1; i < CORDIC_STEPS; i++) tab[i] = atan_pow2(i);
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();
  localparam logic signed [63:0] PI_Q60 = atan_one() <<< 2;

endpackage

// ===== rtl/smas_queue.sv =====
`timescale 1ns / 1ps
module smas_queue import smas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/smas_front.sv =====
`timescale 1ns / 1ps
module smas_front import smas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pixel,
  input  logic [SIZE_W-1:0] width_c,
  input  logic [SIZE_W-1:0] height_c,
  input  logic [7:0]        threshold,
  output logic              push,
  output job_t              push_job,
  input  logic              q_full
);

  front_state_t state, state_next;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_up;
  logic [PIX_W-1:0] rd_mid;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] win [6];
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  logic              res_valid;
  logic              done;
  logic [9:0]        sum_px, sum_nx, sum_py, sum_ny;
  logic signed [11:0] sx_w, sy_w;
  logic [11:0]       abs_x, abs_y, mag_w;
  logic [ROW_W-1:0]  ir;
  logic [COL_W-1:0]  ic;
  logic              row_dup0, row_dupl, col_dup0, col_dupl;
  logic              end_col, end_row;
  logic [SIZE_W-1:0] h_m1, h_m2, w_m1, w_m2;

  assign in_ready = (state == FR_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= FR_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (in_valid) state_next = FR_CALC;
      FR_CALC: if (done) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // registered line store read at accept
  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      rd_up  <= upper_mem[col_count];
      rd_mid <= middle_mem[col_count];
      pix_r  <= pixel;
    end
    if (state == FR_CALC && done) begin
      upper_mem[col_count]  <= rd_mid;
      middle_mem[col_count] <= pix_r;
    end
  end

  always_comb begin
    sum_px = {2'b0, rd_up} + {1'b0, rd_mid, 1'b0} + {2'b0, pix_r};
    sum_nx = {2'b0, win[0]} + {1'b0, win[1], 1'b0} + {2'b0, win[2]};
    sum_py = {2'b0, win[2]} + {1'b0, win[5], 1'b0} + {2'b0, pix_r};
    sum_ny = {2'b0, win[0]} + {1'b0, win[3], 1'b0} + {2'b0, rd_up};
    sx_w   = $signed({2'b0, sum_px}) - $signed({2'b0, sum_nx});
    sy_w   = $signed({2'b0, sum_py}) - $signed({2'b0, sum_ny});
    abs_x  = sx_w[11] ? 12'(-sx_w) : 12'(sx_w);
    abs_y  = sy_w[11] ? 12'(-sy_w) : 12'(sy_w);
    mag_w  = abs_x + abs_y;

    h_m1 = height_c - 11'd1;
    h_m2 = height_c - 11'd2;
    w_m1 = width_c - 11'd1;
    w_m2 = width_c - 11'd2;
    ir   = row_count - ROW_W'(1);
    ic   = col_count - COL_W'(1);
    row_dup0 = (ir == ROW_W'(1));
    row_dupl = ({1'b0, ir} == h_m2);
    col_dup0 = (ic == COL_W'(1));
    col_dupl = ({1'b0, ic} == w_m2);
    end_col  = ({1'b0, col_count} + 11'd1 >= width_c);
    end_row  = ({1'b0, row_count} + 11'd1 >= height_c);

    res_valid = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
    done      = !res_valid || !q_full;
    push      = (state == FR_CALC) && res_valid && !q_full;

    push_job.sx         = sx_w[GRAD_W-1:0];
    push_job.sy         = sy_w[GRAD_W-1:0];
    push_job.mag        = (mag_w > 12'd255) ? 8'd255 : mag_w[7:0];
    push_job.need_angle = ((mag_w > 12'd255) ? 8'd255 : mag_w[7:0]) >= threshold;
    push_job.row_a      = row_dup0 ? '0 : ir;
    push_job.row_b      = row_dup0 ? ir : h_m1[ROW_W-1:0];
    push_job.two_rows   = row_dup0 || row_dupl;
    push_job.col_a      = col_dup0 ? '0 : ic;
    push_job.col_b      = col_dup0 ? ic : w_m1[COL_W-1:0];
    push_job.two_cols   = col_dup0 || col_dupl;
    push_job.frame_end  = end_col && end_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (state == FR_CALC && done) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rd_up;
      win[4] <= rd_mid;
      win[5] <= pix_r;
      if (end_col) begin
        col_count <= '0;
        row_count <= end_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/smas_back.sv =====
`timescale 1ns / 1ps
module smas_back import smas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  job_t             head_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_mag,
  output logic [7:0]       out_angle,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic             out_last
);

  back_state_t state, state_next;

  job_t               job;
  logic signed [63:0] x, y, z, off;
  logic [STEP_W-1:0]  iter;
  logic [62:0]        prod_lo;
  logic signed [95:0] prod;
  logic [7:0]         code;
  logic [2:0]         sbit;
  logic               ri, ci;

  logic signed [63:0] phi;
  logic signed [63:0] xs, ys;
  logic signed [62:0] prod_hi;
  logic [7:0]         cand;
  logic signed [16:0] mval;
  logic signed [36:0] sval;
  logic signed [95:0] bound;
  logic               hit;
  logic               load;
  logic               last_res;

  function automatic logic signed [63:0] shr_s(input logic signed [63:0] v,
                                               input logic [STEP_W-1:0] s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = mag >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  assign pop = (state == BK_IDLE) && !q_empty;

  always_comb begin
    phi     = z + off;
    xs      = shr_s(x, iter);
    ys      = shr_s(y, iter);
    prod_hi = $signed(phi[63:32]) * $signed({1'b0, ANG_DEN});
    cand    = code | (8'd1 << sbit);
    mval    = $signed({1'b0, 16'(cand) * 16'd100}) - ANG_OFS;
    sval    = mval * ANG_NUM;
    bound   = {{2{sval[33]}}, sval[33:0], 60'b0};
    hit     = mval[16] ? (prod >= bound)
                       : (prod + $signed({65'b0, ANG_DEN}) > bound);
    load     = (state == BK_EMIT) && (!out_valid || out_ready);
    last_res = (ri == job.two_rows) && (ci == job.two_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (!head_job.need_angle) state_next = BK_EMIT;
          else if (head_job.sx == '0 && head_job.sy == '0) state_next = BK_MUL_LO;
          else state_next = BK_CORDIC;
        end
      end
      BK_CORDIC: if (iter == STEP_W'(CORDIC_STEPS - 1)) state_next = BK_MUL_LO;
      BK_MUL_LO: state_next = BK_MUL_HI;
      BK_MUL_HI: state_next = BK_SEARCH;
      BK_SEARCH: if (sbit == 3'd0) state_next = BK_EMIT;
      BK_EMIT:   if (load && last_res) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        job  <= head_job;
        iter <= '0;
        z    <= '0;
        code <= '0;
        ri   <= 1'b0;
        ci   <= 1'b0;
        if (head_job.sx[GRAD_W-1]) begin
          x   <= 64'(-64'(head_job.sx)) <<< PRESCALE;
          y   <= 64'(-64'(head_job.sy)) <<< PRESCALE;
          off <= head_job.sy[GRAD_W-1] ? -PI_Q60 : PI_Q60;
        end else begin
          x   <= 64'(head_job.sx) <<< PRESCALE;
          y   <= 64'(head_job.sy) <<< PRESCALE;
          off <= '0;
        end
      end
      BK_CORDIC: begin
        if (!y[63]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ATAN_TAB[iter];
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ATAN_TAB[iter];
        end
        iter <= iter + STEP_W'(1);
      end
      BK_MUL_LO: prod_lo <= phi[31:0] * ANG_DEN;
      BK_MUL_HI: begin
        prod <= $signed({33'b0, prod_lo}) + $signed({prod_hi[62], prod_hi, 32'b0});
        code <= '0;
        sbit <= 3'd7;
      end
      BK_SEARCH: begin
        if (hit) code <= cand;
        sbit <= sbit - 3'd1;
      end
      BK_EMIT: begin
        if (load) begin
          if (ci == job.two_cols) begin
            ci <= 1'b0;
            ri <= ~ri;
          end else begin
            ci <= ~ci;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_mag   <= job.mag;
      out_angle <= job.need_angle ? code : 8'd0;
      out_row   <= ri ? job.row_b : job.row_a;
      out_col   <= ci ? job.col_b : job.col_a;
      out_last  <= job.frame_end && last_res;
    end
  end

endmodule

// ===== rtl/sobel_magnitude_angle_stream_core.sv =====
`timescale 1ns / 1ps
// Flow: a pixel is accepted only while the front end is idle; a pixel whose
//   result finds the queue full waits for room. An angle job passes 58 CORDIC
//   steps (none for a zero gradient), the low and high multiply states and 8
//   search steps; then one result is emitted per output position the job covers.
// The back end pops the next job only once the current job is fully emitted.
// Reset: synchronous, active high; clears counters, window, queue and output valid;
module sobel_magnitude_angle_stream_core import smas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] magnitude, [15:8] angle_code,
                                      // [25:16] out_row, [35:26] out_col, rest 0
  output logic        m_axis_tlast,   // frame_last
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // registers return to 640 / 480 / 75 on reset; line stores are not cleared

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [7:0]        angle_thr;
  logic [SIZE_W-1:0] width_c;
  logic [SIZE_W-1:0] height_c;
  reg_index_t        reg_sel;

  logic       push, q_full, q_empty, pop;
  job_t       push_job, head_job;
  logic [7:0] out_mag, out_angle;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      angle_thr    <= THR_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[SIZE_W-1:0];
        REG_ANGLE_THR:    angle_thr    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = {21'b0, frame_width};
      REG_FRAME_HEIGHT: prdata = {21'b0, frame_height};
      REG_ANGLE_THR:    prdata = {24'b0, angle_thr};
      default:          prdata = '0;
    endcase
  end

  // sizes saturated to the supported range
  always_comb begin
    if (frame_width < 11'd4) width_c = 11'd4;
    else if (frame_width > SIZE_W'(MAX_WIDTH)) width_c = SIZE_W'(MAX_WIDTH);
    else width_c = frame_width;
    if (frame_height < 11'd4) height_c = 11'd4;
    else if (frame_height > SIZE_W'(MAX_HEIGHT)) height_c = SIZE_W'(MAX_HEIGHT);
    else height_c = frame_height;
  end

  // front: line stores, window, gradients, output positions
  smas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .pixel    (s_axis_tdata),
    .width_c  (width_c),
    .height_c (height_c),
    .threshold(angle_thr),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // two-entry queue decouples pixel intake from the angle unit
  smas_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .head_job(head_job),
    .empty   (q_empty)
  );

  // back: CORDIC angle, code search, result emission
  smas_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head_job (head_job),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_mag  (out_mag),
    .out_angle(out_angle),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_col, out_row, out_angle, out_mag};

endmodule

// ===== rtl/smas_checker.sv =====
`timescale 1ns / 1ps
`include "sobel_magnitude_angle_stream_core_defines.svh"
module smas_checker import smas_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  `SMAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")
  `SMAS_ASSERT(a_pready, pready, "pready dropped")
  `SMAS_ASSERT(a_quiet_after_rst, $past(rst) |-> !m_axis_tvalid, "result right after reset")
  `SMAS_ASSERT_NEXT(a_thr_readback, psel && penable && pwrite && paddr[3:2] == REG_ANGLE_THR, paddr[3:2] != REG_ANGLE_THR || prdata[7:0] == $past(pwdata[7:0]), "threshold readback mismatch")

endmodule

bind sobel_magnitude_angle_stream_core smas_checker u_smas_checker (.*);
